### design/lkvc_pkg.sv
// Package with sizes and shared types for the LRU key-value cache.
`timescale 1ns / 1ps
package lkvc_pkg;

  // Storage geometry
  localparam int ENTRIES    = 8;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  // Derived widths
  localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int AGE_BITS  = IDX_BITS;
  localparam int CNT_BITS  = $clog2(ENTRIES + 1);
  localparam int CAP_BITS  = 4;
  localparam int CMP_BITS  = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

  localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(8);

  // Operation codes
  typedef enum logic {
    OP_GET = 1'b0,
    OP_SET = 1'b1
  } lkvc_op_e;

  // Result of the parallel tag search
  typedef struct packed {
    logic                hit;
    logic [IDX_BITS-1:0] hit_idx;
    logic [IDX_BITS-1:0] free_idx;
    logic [IDX_BITS-1:0] victim_idx;
  } lkvc_lookup_t;

endpackage

### design/lkvc_lookup.sv
// Parallel key match, free slot and LRU victim search over all entries.
`timescale 1ns / 1ps
module lkvc_lookup (
  input  logic [lkvc_pkg::ENTRIES-1:0]                        valid_i,
  input  logic [lkvc_pkg::ENTRIES-1:0][lkvc_pkg::KEY_BITS-1:0] keys_i,
  input  logic [lkvc_pkg::ENTRIES-1:0][lkvc_pkg::AGE_BITS-1:0] ages_i,
  input  logic [lkvc_pkg::AGE_BITS-1:0]                       oldest_age_i,
  input  logic [lkvc_pkg::KEY_BITS-1:0]                       key_i,
  output lkvc_pkg::lkvc_lookup_t                              result_o
);
  import lkvc_pkg::*;

  // Walk from the top so the lowest-numbered entry wins every search.
  // Valid ages are a permutation of 0..count-1, so the LRU entry is the
  // one whose age equals count-1.
  always_comb begin
    result_o = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_i[i] && (keys_i[i] == key_i)) begin
        result_o.hit     = 1'b1;
        result_o.hit_idx = IDX_BITS'(i);
      end
      if (!valid_i[i]) begin
        result_o.free_idx = IDX_BITS'(i);
      end
      if (valid_i[i] && (ages_i[i] == oldest_age_i)) begin
        result_o.victim_idx = IDX_BITS'(i);
      end
    end
  end

endmodule

### design/lru_key_value_cache_unit.sv
// Top level of the fully associative key-value cache with LRU replacement.
`timescale 1ns / 1ps
// Fully associative key-value cache with least-recently-used replacement.
// Each input transaction is a get or a set and produces exactly one result
// transaction. One transaction is accepted per clock whenever the input register
// is empty or the result register can take data. An accepted request is held
// in the input register, and its result is then loaded into the result
// register, which presents it on the result channel. While a result waits,
// the request in the input register holds and input is stalled. The key is
// compared against every entry and the ages of the entries are updated
// combinationally, between the input register and the result register.
// The store is empty after reset and needs no clearing pass. The capacity
// register is written over its own channel, which is always ready; a
// capacity of zero acts as one and a capacity above the entry count acts as
// the entry count.
module lru_key_value_cache_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lkvc_pkg::CAP_BITS-1:0]     cfg_capacity_i,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              op_i,
  input  logic [lkvc_pkg::KEY_BITS-1:0]     lookup_key_i,
  input  logic [lkvc_pkg::VALUE_BITS-1:0]   write_value_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              hit_o,
  output logic [lkvc_pkg::VALUE_BITS-1:0]   read_value_o,
  output logic                              evicted_o,
  output logic [lkvc_pkg::KEY_BITS-1:0]     evicted_key_o
);
  import lkvc_pkg::*;

  // Capacity register
  logic [CAP_BITS-1:0] cap_q;

  // Input register
  logic                  in_valid_q;
  lkvc_op_e              op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] wval_q;

  // Result register
  logic                  out_valid_q;
  logic                  hit_q;
  logic [VALUE_BITS-1:0] rval_q;
  logic                  evict_q;
  logic [KEY_BITS-1:0]   ekey_q;

  // Cache state
  logic [ENTRIES-1:0]                 entry_valid_q, entry_valid_d;
  logic [ENTRIES-1:0][AGE_BITS-1:0]   entry_age_q, entry_age_d;
  logic [ENTRIES-1:0][KEY_BITS-1:0]   entry_key_q;
  logic [ENTRIES-1:0][VALUE_BITS-1:0] entry_value_q;
  logic [CNT_BITS-1:0]                count_q, count_d;

  // Datapath
  logic                advance;
  logic                go;
  logic                is_set;
  logic [AGE_BITS-1:0] oldest_age;
  logic [AGE_BITS-1:0] hit_age;
  logic [CMP_BITS-1:0] cap_ext;
  logic [CMP_BITS-1:0] cap_eff;
  logic                fill;
  logic                insert;
  logic [IDX_BITS-1:0] slot;
  logic                res_hit;
  logic [VALUE_BITS-1:0] res_rval;
  logic                res_evict;
  logic [KEY_BITS-1:0] res_ekey;
  lkvc_lookup_t        lk;

  // Handshakes: the pipe moves whenever the result register can take data
  assign advance     = !out_valid_q || out_ready_i;
  assign go          = in_valid_q && advance;
  assign in_ready_o  = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign read_value_o  = rval_q;
  assign evicted_o     = evict_q;
  assign evicted_key_o = ekey_q;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_capacity_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q   <= lkvc_op_e'(op_i);
      key_q  <= lookup_key_i;
      wval_q <= write_value_i;
    end
  end

  // Tag search
  assign oldest_age = AGE_BITS'(count_q - CNT_BITS'(1));

  lkvc_lookup u_lookup (
    .valid_i      (entry_valid_q),
    .keys_i       (entry_key_q),
    .ages_i       (entry_age_q),
    .oldest_age_i (oldest_age),
    .key_i        (key_q),
    .result_o     (lk)
  );

  // Effective capacity, clamped to 1..ENTRIES
  always_comb begin
    cap_ext = CMP_BITS'(cap_q);
    cap_eff = cap_ext;
    if (cap_ext == '0) begin
      cap_eff = CMP_BITS'(1);
    end else if (cap_ext > CMP_BITS'(ENTRIES)) begin
      cap_eff = CMP_BITS'(ENTRIES);
    end
  end

  assign is_set  = (op_q == OP_SET);
  assign hit_age = entry_age_q[lk.hit_idx];
  assign fill    = CMP_BITS'(count_q) < cap_eff;
  assign insert  = is_set && !lk.hit;
  assign slot    = fill ? lk.free_idx : lk.victim_idx;

  // Result fields
  always_comb begin
    res_hit   = lk.hit;
    res_rval  = '0;
    res_evict = 1'b0;
    res_ekey  = '0;
    if (lk.hit && !is_set) begin
      res_rval = entry_value_q[lk.hit_idx];
    end
    if (insert && !fill) begin
      res_evict = 1'b1;
      res_ekey  = entry_key_q[lk.victim_idx];
    end
  end

  // Next valid bits, ages and fill count
  always_comb begin
    entry_valid_d = entry_valid_q;
    entry_age_d   = entry_age_q;
    count_d       = count_q;
    if (go && lk.hit) begin
      // promote the hit entry; younger entries age by one
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_BITS'(i) == lk.hit_idx) begin
          entry_age_d[i] = '0;
        end else if (entry_valid_q[i] && (entry_age_q[i] < hit_age)) begin
          entry_age_d[i] = entry_age_q[i] + AGE_BITS'(1);
        end
      end
    end else if (go && insert) begin
      // new entry is youngest; every other valid entry ages by one
      for (int i = 0; i < ENTRIES; i++) begin
        if (IDX_BITS'(i) == slot) begin
          entry_age_d[i]   = '0;
          entry_valid_d[i] = 1'b1;
        end else if (entry_valid_q[i]) begin
          entry_age_d[i] = entry_age_q[i] + AGE_BITS'(1);
        end
      end
      if (fill) begin
        count_d = count_q + CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
      entry_age_q   <= '0;
      count_q       <= '0;
    end else begin
      entry_valid_q <= entry_valid_d;
      entry_age_q   <= entry_age_d;
      count_q       <= count_d;
    end
  end

  // Key and value storage
  always_ff @(posedge clk_i) begin
    if (go && lk.hit && is_set) begin
      entry_value_q[lk.hit_idx] <= wval_q;
    end else if (go && insert) begin
      entry_key_q[slot]   <= key_q;
      entry_value_q[slot] <= wval_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      hit_q   <= res_hit;
      rval_q  <= res_rval;
      evict_q <= res_evict;
      ekey_q  <= res_ekey;
    end
  end

  // Checks
  a_count_matches_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CNT_BITS'($countones(entry_valid_q)))
    else $error("fill count out of step with valid bits");

  a_hit_keeps_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && lk.hit |=> $stable(entry_valid_q))
    else $error("hit transaction changed valid bits");

  a_evict_not_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_o |-> !hit_o)
    else $error("eviction reported on a hit");

  a_evict_needs_entries : assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && res_evict |-> (count_q != '0) && entry_valid_q[lk.victim_idx])
    else $error("eviction from an empty or invalid entry");

endmodule
